/* sv/mlm_pkg.sv */
`timescale 1ns / 1ps

package mlm_pkg;

    // Default sizes of the lock table and of each lock's waiter ring.
    localparam int NUM_LOCKS_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    // Fixed field widths of the transaction payloads.
    localparam int OP_W  = 2;
    localparam int ID_W  = 4;
    localparam int PID_W = 8;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_SLEEP = 2'd2
    } t_status;

endpackage

/* sv/mutex_lock_manager_unit.sv */
`timescale 1ns / 1ps

// Mutex lock manager: a table of NUM_LOCKS mutexes, each with an owner and a
// FIFO ring of up to WAIT_DEPTH waiting process ids.
//
// The request channel (i_valid / o_ready) carries one operation per
// transaction: create, acquire or release, with a lock id and the caller's
// pid. The result channel (o_valid / i_ready) returns exactly one transaction
// per request, in request order: a status, the handle claimed by a create and,
// for a release that passed the lock on, the pid of the waiter to wake.
//
// A request is captured in an input register. When that stage fires, the
// table is read and updated in one pass and the result is written into an
// output register. One request is taken every cycle while the receiver
// keeps up; the waiter ring memory is read as the request is captured, with
// the pending update forwarded, so back-to-back requests to the same lock
// see each other's effects.
//
// When the receiver stalls, the result stays in the output register and one
// more request is held in the input register; o_ready then drops until the
// result is taken. Synchronous reset empties both registers and frees every
// lock. The waiter memory is not cleared: only written entries are ever used.
module mutex_lock_manager_unit
    import mlm_pkg::*;
#(
    parameter int NUM_LOCKS  = mlm_pkg::NUM_LOCKS_DEF,
    parameter int WAIT_DEPTH = mlm_pkg::WAIT_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mlm_pkg::OP_W-1:0]  i_opcode,
    input  logic [mlm_pkg::ID_W-1:0]  i_lock_id,
    input  logic [mlm_pkg::PID_W-1:0] i_requester_pid,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mlm_pkg::ST_W-1:0]  o_status,
    output logic [mlm_pkg::ID_W-1:0]  o_new_handle,
    output logic                      o_wake_valid,
    output logic [mlm_pkg::PID_W-1:0] o_wake_pid
);

    // Widths derived from the table sizes.
    localparam int LK_W   = $clog2(NUM_LOCKS);
    localparam int HEAD_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int SLOTS  = NUM_LOCKS * WAIT_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    // Handshake control.
    logic accept;
    logic fire;

    // Input register.
    logic             r_in_valid;
    logic [OP_W-1:0]  r_op;
    logic [LK_W-1:0]  r_lk;
    logic             r_in_range;
    logic [PID_W-1:0] r_pid;

    // Lock table.
    logic [NUM_LOCKS-1:0] r_in_use;
    logic [NUM_LOCKS-1:0] r_own_valid;
    logic [PID_W-1:0]     r_own_pid [NUM_LOCKS];
    logic [HEAD_W-1:0]    r_head    [NUM_LOCKS];
    logic [CNT_W-1:0]     r_count   [NUM_LOCKS];

    // Output register.
    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [ID_W-1:0]  r_handle;
    logic             r_wake_valid;
    logic [PID_W-1:0] r_wake_pid;

    // Waiter memory bypass for a write and a read to the same slot in one cycle.
    logic             r_byp_hit;
    logic [PID_W-1:0] r_byp_data;

    // Current entry of the lock held in the input register.
    logic             cur_use;
    logic             cur_ov;
    logic [PID_W-1:0] cur_opid;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0] cur_count;
    logic             owns;
    logic [SUM_W-1:0] tail_sum;
    logic [HEAD_W-1:0] tail;
    logic [HEAD_W-1:0] head_inc;
    logic [PID_W-1:0] waiter_pid;

    // Lowest free lock for create.
    logic            any_free;
    logic [LK_W-1:0] free_idx;

    // Table update produced by the request in the input register.
    logic              upd_en;
    logic [LK_W-1:0]   upd_lk;
    logic              n_use;
    logic              n_ov;
    logic [PID_W-1:0]  n_opid;
    logic [HEAD_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;

    logic [ST_W-1:0]  n_status;
    logic [ID_W-1:0]  n_handle;
    logic             n_wake_valid;
    logic [PID_W-1:0] n_wake_pid;

    // Read side, addressed by the incoming request.
    logic [LK_W-1:0]   in_lk;
    logic [HEAD_W-1:0] in_head;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PID_W-1:0]  mem_rdata;

    // The stage fires when the output register is empty or being drained.
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_opcode;
            r_lk       <= in_lk;
            r_in_range <= (32'(i_lock_id) < NUM_LOCKS);
            r_pid      <= i_requester_pid;
        end
    end

    // Priority encoder: the lowest index wins.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                any_free = 1'b1;
                free_idx = LK_W'(i);
            end
        end
    end

    assign cur_use   = r_in_use[r_lk];
    assign cur_ov    = r_own_valid[r_lk];
    assign cur_opid  = r_own_pid[r_lk];
    assign cur_head  = r_head[r_lk];
    assign cur_count = r_count[r_lk];
    assign owns      = cur_ov && (cur_opid == r_pid);

    // Ring positions: the tail for an append and the head after a pop.
    assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_count);
    assign tail     = (tail_sum >= SUM_W'(WAIT_DEPTH))
                    ? HEAD_W'(tail_sum - SUM_W'(WAIT_DEPTH))
                    : HEAD_W'(tail_sum);
    assign head_inc = (cur_head == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    assign waiter_pid = r_byp_hit ? r_byp_data : mem_rdata;
    assign mem_waddr  = ADDR_W'(r_lk) * ADDR_W'(WAIT_DEPTH) + ADDR_W'(tail);

    always_comb begin
        n_status     = ST_FAIL;
        n_handle     = '0;
        n_wake_valid = 1'b0;
        n_wake_pid   = '0;
        upd_en       = 1'b0;
        upd_lk       = r_lk;
        n_use        = cur_use;
        n_ov         = cur_ov;
        n_opid       = cur_opid;
        n_head       = cur_head;
        n_count      = cur_count;
        mem_we       = 1'b0;
        unique case (r_op)
            OP_CREATE: begin
                if (any_free) begin
                    n_status = ST_OK;
                    n_handle = ID_W'(free_idx);
                    upd_en   = 1'b1;
                    upd_lk   = free_idx;
                    n_use    = 1'b1;
                    n_ov     = 1'b0;
                    n_opid   = '0;
                    n_head   = '0;
                    n_count  = '0;
                end
            end
            OP_ACQUIRE: begin
                if (r_in_range && cur_use) begin
                    if (owns) begin
                        n_status = ST_OK;
                    end else if (!cur_ov) begin
                        n_status = ST_OK;
                        upd_en   = 1'b1;
                        n_ov     = 1'b1;
                        n_opid   = r_pid;
                    end else if (cur_count < CNT_W'(WAIT_DEPTH)) begin
                        n_status = ST_SLEEP;
                        upd_en   = 1'b1;
                        n_count  = cur_count + 1'b1;
                        mem_we   = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                if (r_in_range && cur_use && owns) begin
                    n_status = ST_OK;
                    upd_en   = 1'b1;
                    if (cur_count != '0) begin
                        // Hand the lock straight to the oldest waiter.
                        n_head       = head_inc;
                        n_count      = cur_count - 1'b1;
                        n_opid       = waiter_pid;
                        n_wake_valid = 1'b1;
                        n_wake_pid   = waiter_pid;
                    end else begin
                        n_ov   = 1'b0;
                        n_opid = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!fire) begin
            upd_en = 1'b0;
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_own_valid <= '0;
            for (int i = 0; i < NUM_LOCKS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (upd_en) begin
            r_in_use[upd_lk]    <= n_use;
            r_own_valid[upd_lk] <= n_ov;
            r_head[upd_lk]      <= n_head;
            r_count[upd_lk]     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_en) begin
            r_own_pid[upd_lk] <= n_opid;
        end
    end

    // The head read for an incoming request must see the update that fires
    // in the same cycle, since both land at the same edge.
    assign in_lk     = LK_W'(i_lock_id);
    assign in_head   = (upd_en && (upd_lk == in_lk)) ? n_head : r_head[in_lk];
    assign mem_raddr = ADDR_W'(in_lk) * ADDR_W'(WAIT_DEPTH) + ADDR_W'(in_head);

    mlm_ram #(
        .WIDTH (PID_W),
        .DEPTH (SLOTS)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_pid),
        .i_re    (accept),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (accept) begin
            r_byp_hit <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data <= r_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status     <= n_status;
            r_handle     <= n_handle;
            r_wake_valid <= n_wake_valid;
            r_wake_pid   <= n_wake_pid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_new_handle = r_handle;
    assign o_wake_valid = r_wake_valid;
    assign o_wake_pid   = r_wake_pid;

endmodule

/* sv/mlm_ram.sv */
`timescale 1ns / 1ps

module mlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* sv/mlm_checker.sv */
`timescale 1ns / 1ps

module mlm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [mlm_pkg::ST_W-1:0]  o_status,
    input logic [mlm_pkg::ID_W-1:0]  o_new_handle,
    input logic                      o_wake_valid,
    input logic [mlm_pkg::PID_W-1:0] o_wake_pid
);
    import mlm_pkg::*;

    // With the output register empty, the input side can always take a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused while no result is waiting");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_new_handle)
            && $stable(o_wake_valid) && $stable(o_wake_pid))
        else $error("result changed while stalled");

    // Only a successful operation can hand a lock to a waiter.
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake_valid |-> o_status == ST_OK && o_new_handle == '0)
        else $error("wakeup reported without a successful release");

    // A handle is only reported by a successful create.
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_new_handle == '0 && !o_wake_valid)
        else $error("handle or wakeup on a failed or sleeping operation");

    // Without a wakeup the wakeup pid reads zero.
    a_wake_pid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wake_valid |-> o_wake_pid == '0)
        else $error("wakeup pid set without wakeup");

endmodule

bind mutex_lock_manager_unit mlm_checker u_mlm_checker (.*);
